// ===== rtl/nearest_node_search_top_assert.svh =====
// Assertion macros for the nearest-node search block.
// Included by modules that check their own sequencing; expects i_clk and i_rst_n in scope.
`ifndef NEAREST_NODE_SEARCH_TOP_ASSERT_SVH
`define NEAREST_NODE_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define NNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define NNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NNS_ASSERT_NOW(lbl, ante, cons, msg)
`define NNS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/nns_pkg.sv =====
// Shared types and constants for the nearest-node search block.
// No dependencies; used by every module under rtl.
package nns_pkg;

    // Field widths
    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * COORD_W + 1;
    localparam int DIST_W      = PROD_W + 1;
    localparam int NODE_W      = 3 * COORD_W;
    localparam int INDEX_W     = 10;
    localparam int CFG_COUNT_W = 11;
    localparam int CFG_DIST_W  = 23;
    localparam int LIMIT_SQ_W  = 2 * CFG_DIST_W;

    // Radius reset: 1000.0 in fixed point
    localparam int FRACTION_BITS = 4;
    localparam logic [CFG_DIST_W-1:0] MAX_DIST_RESET = CFG_DIST_W'(1000 << FRACTION_BITS);

    // Command codes (tuser of the input stream)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_MAX_DIST   = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_state;

    // Tag that travels with each node through the distance pipeline
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [INDEX_W-1:0] idx;
    } t_tag;

endpackage

// ===== rtl/nearest_node_search_top.sv =====
// Nearest-node search over a table of 3D positions in signed fixed point.
// A write command (tuser 0) stores one position. A query (tuser 1) reads the
// table one entry per cycle through the single memory read port and occupies
// the block through the accepting cycle, the scan of min(node_count,
// NODE_CAPACITY) entries, the memory read register, the distance pipeline
// and the loading of the result once the result side is free. A zero-count
// query goes straight to loading the result. The input is not ready during a
// query; a finished result waits in an output register while new words are
// taken. Only nodes strictly inside max_distance count, the lowest index wins
// a tie, and closest_index is 0 when nothing is found. The table is not
// cleared at reset: entries must be written before a query reaches them.
// Depends on nns_pkg, nns_node_mem, nns_dist_unit and the assertion header.
`include "nearest_node_search_top_assert.svh"

module nearest_node_search_top #(
    parameter int NODE_CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // node_index[9:0], pos_x[33:10], pos_y[57:34],
                                       // pos_z[81:58], zero fill
    input  logic        s_axis_tuser,  // command
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // closest_index[9:0], zero fill
    output logic        m_axis_tuser,  // found
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [22:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(NODE_CAPACITY);
    localparam int CNT_W  = $clog2(NODE_CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > nns_pkg::CFG_COUNT_W) ? CNT_W : nns_pkg::CFG_COUNT_W;
    localparam int CW     = nns_pkg::COORD_W;
    localparam int IW     = nns_pkg::INDEX_W;

    // Input word fields
    logic [IW-1:0]                    w_in_idx;
    logic signed [CW-1:0]             w_in_x, w_in_y, w_in_z;
    logic                             w_in_acc;
    logic                             w_is_query;

    // Configuration registers
    logic [nns_pkg::CFG_COUNT_W-1:0]  r_node_count;
    logic [nns_pkg::CFG_DIST_W-1:0]   r_max_dist;

    // Sequencer and search state
    nns_pkg::t_state                  r_state, n_state;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [CNT_W-1:0]                 r_last_cnt, n_last_cnt;
    logic [nns_pkg::DIST_W-1:0]       r_best, n_best;
    logic [IW-1:0]                    r_best_idx, n_best_idx;
    logic                             r_found, n_found;
    nns_pkg::t_tag                    r_tag_rd, n_tag_rd;
    logic signed [CW-1:0]             r_qx, r_qy, r_qz;

    // Derived values
    logic [CMP_W-1:0]                 w_count_ext, w_cap, w_eff, w_cnt_ext, w_widx_ext;
    logic [CNT_W-1:0]                 w_eff_cnt;
    logic [nns_pkg::LIMIT_SQ_W-1:0]   w_limit_sq;
    logic                             w_wr_en;
    logic [nns_pkg::NODE_W-1:0]       w_rd_node;
    logic [nns_pkg::DIST_W-1:0]       w_dist;
    nns_pkg::t_tag                    w_dist_tag;
    logic                             w_out_load;

    // Output register
    logic                             r_out_valid;
    logic                             r_out_found;
    logic [IW-1:0]                    r_out_idx;

    // Unpack the input word
    assign w_in_idx   = s_axis_tdata[IW-1:0];
    assign w_in_x     = s_axis_tdata[IW+CW-1:IW];
    assign w_in_y     = s_axis_tdata[IW+2*CW-1:IW+CW];
    assign w_in_z     = s_axis_tdata[IW+3*CW-1:IW+2*CW];
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_is_query = (s_axis_tuser == nns_pkg::CMD_QUERY);

    assign s_axis_tready = (r_state == nns_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_max_dist   <= nns_pkg::MAX_DIST_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nns_pkg::CFG_NODE_COUNT: begin
                    r_node_count <= i_cfg_data[nns_pkg::CFG_COUNT_W-1:0];
                end
                nns_pkg::CFG_MAX_DIST: begin
                    r_max_dist <= i_cfg_data;
                end
                default: begin
                    r_node_count <= r_node_count;
                end
            endcase
        end
    end

    // Clamp the count to the table size
    assign w_count_ext = CMP_W'(r_node_count);
    assign w_cap       = CMP_W'(NODE_CAPACITY);
    assign w_eff       = (w_count_ext > w_cap) ? w_cap : w_count_ext;
    assign w_eff_cnt   = w_eff[CNT_W-1:0];
    assign w_cnt_ext   = CMP_W'(r_cnt);
    assign w_widx_ext  = CMP_W'(w_in_idx);

    // Squared radius, loaded as the starting best distance
    assign w_limit_sq = r_max_dist * r_max_dist;

    // Drop writes beyond the table
    assign w_wr_en = w_in_acc && !w_is_query && (w_widx_ext < w_cap);

    nns_node_mem #(
        .DEPTH (NODE_CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_widx_ext[ADDR_W-1:0]),
        .i_wr_data ({w_in_z, w_in_y, w_in_x}),
        .i_rd_en   (r_state == nns_pkg::ST_SCAN),
        .i_rd_addr (r_cnt[ADDR_W-1:0]),
        .o_rd_data (w_rd_node)
    );

    nns_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_qz    (r_qz),
        .i_node  (w_rd_node),
        .i_tag   (r_tag_rd),
        .o_dist  (w_dist),
        .o_tag   (w_dist_tag)
    );

    // Sequencer and running minimum
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_last_cnt = r_last_cnt;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_found    = r_found;
        n_tag_rd   = '0;
        case (r_state)
            nns_pkg::ST_IDLE: begin
                if (w_in_acc && w_is_query) begin
                    n_cnt      = '0;
                    n_last_cnt = w_eff_cnt - CNT_W'(1);
                    n_best     = nns_pkg::DIST_W'(w_limit_sq);
                    n_best_idx = '0;
                    n_found    = 1'b0;
                    n_state    = (w_eff_cnt == '0) ? nns_pkg::ST_HOLD : nns_pkg::ST_SCAN;
                end
            end
            nns_pkg::ST_SCAN: begin
                n_tag_rd.valid = 1'b1;
                n_tag_rd.last  = (r_cnt == r_last_cnt);
                n_tag_rd.idx   = w_cnt_ext[IW-1:0];
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == r_last_cnt) begin
                    n_state = nns_pkg::ST_DRAIN;
                end
            end
            nns_pkg::ST_DRAIN: begin
                if (w_dist_tag.valid && w_dist_tag.last) begin
                    n_state = nns_pkg::ST_HOLD;
                end
            end
            nns_pkg::ST_HOLD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = nns_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nns_pkg::ST_IDLE;
            end
        endcase
        // Keep the strictly closer node; earlier index holds on a tie
        if (w_dist_tag.valid && (w_dist < r_best)) begin
            n_best     = w_dist;
            n_best_idx = w_dist_tag.idx;
            n_found    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= nns_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_last_cnt <= '0;
            r_found    <= 1'b0;
            r_best_idx <= '0;
            r_tag_rd   <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_last_cnt <= n_last_cnt;
            r_found    <= n_found;
            r_best_idx <= n_best_idx;
            r_tag_rd   <= n_tag_rd;
        end
    end

    // Hold the query point and best distance for the scan
    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        if (w_in_acc && w_is_query) begin
            r_qx <= w_in_x;
            r_qy <= w_in_y;
            r_qz <= w_in_z;
        end
    end

    // Result word register
    assign w_out_load = (r_state == nns_pkg::ST_HOLD) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found <= r_found;
            r_out_idx   <= r_found ? r_best_idx : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {(16 - IW)'(0), r_out_idx};

    // Checks on the sequencer and the result
    `NNS_ASSERT_NOW(a_scan_bound, r_state == nns_pkg::ST_SCAN, r_cnt <= r_last_cnt,
        "scan counter ran past the last entry")
    `NNS_ASSERT_NOW(a_tag_in_query, w_dist_tag.valid,
        (r_state == nns_pkg::ST_SCAN) || (r_state == nns_pkg::ST_DRAIN),
        "distance result outside a query")
    `NNS_ASSERT_NOW(a_miss_index_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'd0,
        "nonzero index without a hit")
    `NNS_ASSERT_NEXT(a_query_starts, w_in_acc && w_is_query && (w_eff_cnt != '0),
        r_state == nns_pkg::ST_SCAN, "query did not start a scan")

endmodule

// ===== rtl/nns_node_mem.sv =====
// Node position table: one write port, one registered read port.
// Depends on nns_pkg for the packed node width.
module nns_node_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic [nns_pkg::NODE_W-1:0]        i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic [nns_pkg::NODE_W-1:0]        o_rd_data
);

    logic [nns_pkg::NODE_W-1:0] r_mem [DEPTH];
    logic [nns_pkg::NODE_W-1:0] r_rd_data;

    // Store a node position
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry per cycle while the read is enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/nns_dist_unit.sv =====
// Squared-distance pipeline: difference, square, three-way sum.
// Depends on nns_pkg; takes one node per cycle, registered at each of those steps.
module nns_dist_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [nns_pkg::COORD_W-1:0] i_qx,
    input  logic signed [nns_pkg::COORD_W-1:0] i_qy,
    input  logic signed [nns_pkg::COORD_W-1:0] i_qz,
    input  logic [nns_pkg::NODE_W-1:0]        i_node,
    input  nns_pkg::t_tag                     i_tag,
    output logic [nns_pkg::DIST_W-1:0]        o_dist,
    output nns_pkg::t_tag                     o_tag
);

    localparam int CW = nns_pkg::COORD_W;

    logic signed [CW-1:0]                  w_nx, w_ny, w_nz;
    logic signed [nns_pkg::DIFF_W-1:0]     r_dx, r_dy, r_dz;
    logic signed [2*nns_pkg::DIFF_W-1:0]   w_px, w_py, w_pz;
    logic [nns_pkg::PROD_W-1:0]            r_px, r_py, r_pz;
    logic [nns_pkg::DIST_W-1:0]            r_sum;
    nns_pkg::t_tag                         r_tag_d, r_tag_p, r_tag_s;

    // Unpack node word {z, y, x}
    assign w_nx = i_node[CW-1:0];
    assign w_ny = i_node[2*CW-1:CW];
    assign w_nz = i_node[3*CW-1:2*CW];

    // Stage 1: signed differences, exact in one extra bit
    always_ff @(posedge i_clk) begin
        r_dx <= nns_pkg::DIFF_W'(i_qx) - nns_pkg::DIFF_W'(w_nx);
        r_dy <= nns_pkg::DIFF_W'(i_qy) - nns_pkg::DIFF_W'(w_ny);
        r_dz <= nns_pkg::DIFF_W'(i_qz) - nns_pkg::DIFF_W'(w_nz);
    end

    // Stage 2: squares, never negative
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        r_px <= w_px[nns_pkg::PROD_W-1:0];
        r_py <= w_py[nns_pkg::PROD_W-1:0];
        r_pz <= w_pz[nns_pkg::PROD_W-1:0];
    end

    // Stage 3: sum of squares
    always_ff @(posedge i_clk) begin
        r_sum <= nns_pkg::DIST_W'(r_px) + nns_pkg::DIST_W'(r_py) + nns_pkg::DIST_W'(r_pz);
    end

    // Carry the tag alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_d <= '0;
            r_tag_p <= '0;
            r_tag_s <= '0;
        end else begin
            r_tag_d <= i_tag;
            r_tag_p <= r_tag_d;
            r_tag_s <= r_tag_p;
        end
    end

    assign o_dist = r_sum;
    assign o_tag  = r_tag_s;

endmodule
